@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level of the demosaic block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bbd assertion failed");
`define BBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbd assertion failed");
`else
`define BBD_ASSERT(lbl, prop)
`define BBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/bbd_pkg.sv @@
// Shared types and constants of the BGGR bilinear demosaic block.
package bbd_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned OUT_COORD_W = 9;
  localparam int unsigned CFG_W       = 10;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CFG_W-1:0] cfg_val_t;
  typedef logic [0:0]       cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

  localparam cfg_val_t FRAME_WIDTH_RST  = 10'd316;
  localparam cfg_val_t FRAME_HEIGHT_RST = 10'd208;

endpackage

@@ rtl/bayer_bggr_bilinear_demosaic.sv @@
// Top level of the BGGR Bayer bilinear demosaic block.
//
// Raw BGGR bytes enter one per beat in raster order; frame_width and frame_height are
// clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT], and a write to either restarts the frame.
// Both previous rows live in one line memory of MAX_WIDTH words (one read and one write
// per beat, read data registered), so an input beat is taken every cycle unless the
// emitter is busy. Once the sample at (c, r) with c >= 2 and r >= 2 is in, centre
// (c-1, r-1) is interpolated and leaves as one RGB pixel with its column and row;
// border pixels repeat the nearest interior centre, so a centre next to a corner
// yields up to 4 output beats, emitted one per cycle while the output is ready,
// which holds the input. tlast marks the last output beat caused by one input beat.
// The line memory holds no reset value; a frame's first two rows fill it before use.
`include "assert_macros.svh"

module bayer_bggr_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  cfg_idx_t               cfg_index_i,
  input  cfg_val_t               cfg_data_i,
  // raw input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] raw_sample
  // pixel output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_col, out_row, red, green, blue
  output logic                   m_axis_tlast    // run_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WDW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int HDW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  // ---------------------------------------------------------------- config
  cfg_val_t width_q, height_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic [WDW-1:0] w_ext, w_clamp;
  logic [HDW-1:0] h_ext, h_clamp;
  logic [CW:0]    w_eff;
  logic [RW:0]    h_eff;
  logic [CW:0]    w_m1_ext;
  logic [RW:0]    h_m1_ext;

  always_comb begin
    w_ext = WDW'(width_q);
    h_ext = HDW'(height_q);
    priority if (w_ext < WDW'(3)) begin
      w_clamp = WDW'(3);
    end else if (w_ext > WDW'(MAX_WIDTH)) begin
      w_clamp = WDW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    priority if (h_ext < HDW'(3)) begin
      h_clamp = HDW'(3);
    end else if (h_ext > HDW'(MAX_HEIGHT)) begin
      h_clamp = HDW'(MAX_HEIGHT);
    end else begin
      h_clamp = h_ext;
    end
    w_eff    = w_clamp[CW:0];
    h_eff    = h_clamp[RW:0];
    w_m1_ext = w_eff - (CW+1)'(1);
    h_m1_ext = h_eff - (RW+1)'(1);
  end

  // ---------------------------------------------------------------- input side
  logic          in_acc;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc = {1'b0, row_q} + (RW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
      end else begin
        col_q <= col_inc[CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic          s1_valid_q;
  pix_t          s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_job, s1_adv;

  logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] lb_rd_q;
  pix_t               top_pix, mid_pix;

  assign top_pix = lb_rd_q[PIX_W-1:0];
  assign mid_pix = lb_rd_q[2*PIX_W-1:PIX_W];

  // line memory word: {line one back, line two back}
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lb_rd_q <= lb_mem[col_q];
    end
    if (s1_adv) begin
      lb_mem[s1_col_q] <= {s1_pix_q, mid_pix};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= s_axis_tdata;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // two most recent window columns; index [row][0] older, [row][1] newer
  pix_t win_q [3][2];
  pix_t new_col [3];

  assign new_col[0] = top_pix;
  assign new_col[1] = mid_pix;
  assign new_col[2] = s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= new_col[i];
      end
    end
  end

  // interpolation
  logic [PIX_W:0]   lr_sum, ud_sum;
  logic [PIX_W+1:0] cor_sum, lrud_sum;
  pix_t             ctr, red_d, grn_d, blu_d;
  logic             cy_odd, cx_odd;

  always_comb begin
    ctr      = win_q[1][1];
    lr_sum   = {1'b0, win_q[1][0]} + {1'b0, mid_pix};
    ud_sum   = {1'b0, win_q[0][1]} + {1'b0, win_q[2][1]};
    cor_sum  = {2'b0, win_q[0][0]} + {2'b0, top_pix} + {2'b0, win_q[2][0]} + {2'b0, s1_pix_q};
    lrud_sum = {1'b0, lr_sum} + {1'b0, ud_sum};
    cy_odd   = ~s1_row_q[0];
    cx_odd   = ~s1_col_q[0];
    unique case ({cy_odd, cx_odd})
      2'b11: begin
        red_d = ctr;
        grn_d = lrud_sum[PIX_W+1:2];
        blu_d = cor_sum[PIX_W+1:2];
      end
      2'b10: begin
        red_d = lr_sum[PIX_W:1];
        grn_d = ctr;
        blu_d = ud_sum[PIX_W:1];
      end
      2'b01: begin
        red_d = ud_sum[PIX_W:1];
        grn_d = ctr;
        blu_d = lr_sum[PIX_W:1];
      end
      default: begin
        red_d = cor_sum[PIX_W+1:2];
        grn_d = lrud_sum[PIX_W+1:2];
        blu_d = ctr;
      end
    endcase
  end

  // border lists
  logic [CW-1:0] cx, cols_d [3];
  logic [RW-1:0] cy, rows_d [3];
  logic          c_first, c_last, r_first, r_last;
  logic [1:0]    nc_d, nr_d;

  always_comb begin
    cx        = s1_col_q - CW'(1);
    cy        = s1_row_q - RW'(1);
    c_first   = (cx == CW'(1));
    r_first   = (cy == RW'(1));
    c_last    = (({1'b0, cx} + (CW+1)'(2)) == w_eff);
    r_last    = (({1'b0, cy} + (RW+1)'(2)) == h_eff);
    cols_d[0] = c_first ? '0 : cx;
    cols_d[1] = c_first ? cx : w_m1_ext[CW-1:0];
    cols_d[2] = w_m1_ext[CW-1:0];
    rows_d[0] = r_first ? '0 : cy;
    rows_d[1] = r_first ? cy : h_m1_ext[RW-1:0];
    rows_d[2] = h_m1_ext[RW-1:0];
    nc_d      = 2'd1 + {1'b0, c_first} + {1'b0, c_last};
    nr_d      = 2'd1 + {1'b0, r_first} + {1'b0, r_last};
  end

  // ---------------------------------------------------------------- emitter
  logic          job_valid_q;
  pix_t          job_red_q, job_grn_q, job_blu_q;
  logic [CW-1:0] job_cols_q [3];
  logic [RW-1:0] job_rows_q [3];
  logic [1:0]    job_nc_q, job_nr_q, ci_q, ri_q, k_q;
  logic          out_free, emit, job_last, job_done, ci_end;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit     = job_valid_q && out_free;
  assign ci_end   = (ci_q == job_nc_q - 2'd1);
  assign job_last = (ci_end && (ri_q == job_nr_q - 2'd1)) || (k_q == 2'd3);
  assign job_done = emit && job_last;

  assign s1_job        = s1_valid_q && (s1_col_q >= CW'(2)) && (s1_row_q >= RW'(2));
  assign s1_adv        = s1_valid_q && (!s1_job || !job_valid_q || job_done);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      ci_q        <= '0;
      ri_q        <= '0;
      k_q         <= '0;
    end else if (s1_adv && s1_job) begin
      job_valid_q <= 1'b1;
      ci_q        <= '0;
      ri_q        <= '0;
      k_q         <= '0;
    end else if (job_done) begin
      job_valid_q <= 1'b0;
    end else if (emit) begin
      k_q <= k_q + 2'd1;
      if (ci_end) begin
        ci_q <= '0;
        ri_q <= ri_q + 2'd1;
      end else begin
        ci_q <= ci_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_job) begin
      job_red_q <= red_d;
      job_grn_q <= grn_d;
      job_blu_q <= blu_d;
      job_nc_q  <= nc_d;
      job_nr_q  <= nr_d;
      for (int i = 0; i < 3; i++) begin
        job_cols_q[i] <= cols_d[i];
        job_rows_q[i] <= rows_d[i];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic [CW+OUT_COORD_W-1:0] col_pad;
  logic [RW+OUT_COORD_W-1:0] row_pad;
  logic                      m_valid_q, m_last_q;
  logic [OUT_TDATA_W-1:0]    m_data_q;

  assign col_pad = {{OUT_COORD_W{1'b0}}, job_cols_q[ci_q]};
  assign row_pad = {{OUT_COORD_W{1'b0}}, job_rows_q[ri_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {6'b0, job_blu_q, job_grn_q, job_red_q,
                   row_pad[OUT_COORD_W-1:0], col_pad[OUT_COORD_W-1:0]};
      m_last_q <= job_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // ---------------------------------------------------------------- checks
  `BBD_ASSERT(a_col_idx_in_range, job_valid_q |-> (ci_q < job_nc_q))
  `BBD_ASSERT(a_row_idx_in_range, job_valid_q |-> (ri_q < job_nr_q))
  `BBD_ASSERT_NEXT(a_last_beat_marked, emit && job_last, m_axis_tvalid && m_axis_tlast)
  `BBD_ASSERT_NEXT(a_job_loaded, s1_adv && s1_job, job_valid_q && (k_q == 2'd0))

endmodule

@@ tb/bayer_bggr_bilinear_demosaic_tb.sv @@
// Testbench for the BGGR bilinear demosaic block: streamed raw frames checked against a predictor.
`timescale 1ns / 1ps

module bayer_bggr_bilinear_demosaic_tb
  import bbd_pkg::*;
();

  localparam int unsigned FRAME_MAX  = 512;
  localparam int unsigned RAND_ITEMS = 330;
  localparam int unsigned CYCLE_CAP  = 1500000;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] col;
    logic [OUT_COORD_W-1:0] row;
    pix_t                   red;
    pix_t                   green;
    pix_t                   blue;
    logic                   last;
  } rgb_pix_t;

  class bilinear_checker;
    rgb_pix_t    pending_pixels[$];
    pix_t        prev2[FRAME_MAX];
    pix_t        prev1[FRAME_MAX];
    pix_t        win[3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    cfg_val_t    width_reg;
    cfg_val_t    height_reg;
    int unsigned mismatches;

    function new();
      for (int i = 0; i < FRAME_MAX; i++) begin
        prev2[i] = '0;
        prev1[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(cfg_val_t v);
      if (v < 3) return 3;
      if (v > FRAME_MAX) return FRAME_MAX;
      return 32'(v);
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_val_t val);
      case (idx)
        REG_FRAME_WIDTH: width_reg = val;
        REG_FRAME_HEIGHT: height_reg = val;
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    function int fan_out(int unsigned ctr, int unsigned size, output int unsigned list[3]);
      int n;
      n = 0;
      list[0] = 0;
      list[1] = 0;
      list[2] = 0;
      if (ctr == 1) begin
        list[n] = 0;
        n++;
      end
      list[n] = ctr;
      n++;
      if (ctr + 2 == size) begin
        list[n] = size - 1;
        n++;
      end
      return n;
    endfunction

    function void take_sample(pix_t v);
      int unsigned w, h, cx, cy, ctr, lr, ud, cor, red, grn, blu;
      int unsigned rows[3];
      int unsigned cols[3];
      int          nr, nc, n, total;
      pix_t        top, mid;
      rgb_pix_t    px;
      w   = clamp_dim(width_reg);
      h   = clamp_dim(height_reg);
      top = prev2[col_pos];
      mid = prev1[col_pos];
      prev2[col_pos] = mid;
      prev1[col_pos] = v;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = v;
      if (col_pos >= 2 && row_pos >= 2) begin
        cx  = col_pos - 1;
        cy  = row_pos - 1;
        ctr = 32'(win[1][1]);
        lr  = 32'(win[1][0]) + 32'(win[1][2]);
        ud  = 32'(win[0][1]) + 32'(win[2][1]);
        cor = 32'(win[0][0]) + 32'(win[0][2]) + 32'(win[2][0]) + 32'(win[2][2]);
        if (cy[0]) begin
          if (cx[0]) begin
            red = ctr;      grn = (lr + ud) >> 2; blu = cor >> 2;
          end else begin
            red = lr >> 1;  grn = ctr;            blu = ud >> 1;
          end
        end else begin
          if (cx[0]) begin
            red = ud >> 1;  grn = ctr;            blu = lr >> 1;
          end else begin
            red = cor >> 2; grn = (lr + ud) >> 2; blu = ctr;
          end
        end
        nr    = fan_out(cy, h, rows);
        nc    = fan_out(cx, w, cols);
        total = (nr * nc > 4) ? 4 : nr * nc;
        n     = 0;
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            if (n < total) begin
              px.col   = cols[j][OUT_COORD_W-1:0];
              px.row   = rows[i][OUT_COORD_W-1:0];
              px.red   = red[7:0];
              px.green = grn[7:0];
              px.blue  = blu[7:0];
              px.last  = (n == total - 1);
              pending_pixels.push_back(px);
              n++;
            end
          end
        end
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch: %s", what);
      mismatches++;
    endtask

    task cmp_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_pixel(logic [OUT_TDATA_W-1:0] data, logic last);
      rgb_pix_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tdata=%h", data));
        return;
      end
      want = pending_pixels.pop_front();
      cmp_field("out_col", 32'(data[8:0]), 32'(want.col));
      cmp_field("out_row", 32'(data[17:9]), 32'(want.row));
      cmp_field("red", 32'(data[25:18]), 32'(want.red));
      cmp_field("green", 32'(data[33:26]), 32'(want.green));
      cmp_field("blue", 32'(data[41:34]), 32'(want.blue));
      cmp_field("run_last", 32'(last), 32'(want.last));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  cfg_idx_t               cfg_index_i = REG_FRAME_WIDTH;
  cfg_val_t               cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  bilinear_checker sb;
  bit              quiet = 1'b0;
  int              out_hold = 0;
  int unsigned     cycles = 0;

  bayer_bggr_bilinear_demosaic u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_hold != 0) begin
      out_hold      <= out_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_hold      <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.take_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic set_geometry(input cfg_val_t w, input cfg_val_t h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      cfg_index_i <= REG_FRAME_WIDTH;
      cfg_data_i  <= w;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(input pix_t v);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) push_sample(pix_t'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned total, n;
    cfg_val_t    w, h;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame: one centre fans out to more pixels than a run carries
    set_geometry(10'd0, 10'd1);
    repeat (9) push_sample(8'hFF);
    drain();
    // 4x4 frame: every colour phase once, border pixels on all sides
    set_geometry(10'd4, 10'd4);
    for (int i = 0; i < 16; i++)
      push_sample((i % 3 == 0) ? 8'h00 : ((i % 3 == 1) ? 8'hFF : 8'hA5));
    drain();

    total = 0;
    while (total < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0: w = cfg_val_t'($urandom_range(0, 2));
        1: w = cfg_val_t'(3);
        5: w = cfg_val_t'($urandom_range(17, 40));
        default: w = cfg_val_t'($urandom_range(4, 16));
      endcase
      case ($urandom_range(0, 4))
        0: h = cfg_val_t'($urandom_range(0, 2));
        1: h = cfg_val_t'(3);
        default: h = cfg_val_t'($urandom_range(4, 10));
      endcase
      n     = $urandom_range(20, 90);
      quiet = ($urandom_range(0, 3) == 0);
      set_geometry(w, h);
      push_random(n);
      drain();
      total += n;
    end

    quiet = 1'b0;
    set_geometry(10'd1023, 10'd3);
    push_random(40);
    drain();
    quiet = ($urandom_range(0, 1) == 0);
    set_geometry(10'd3, 10'd1023);
    push_random(60);
    drain();

    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
